>>> rtl/core/bdrl_pkg.sv
// bdrl_pkg: shared types and constants for the button debounce block
// request and response payload structs, csr register indexes, reset values
// no dependencies
`default_nettype none

package bdrl_pkg;

   localparam int CSR_DATA_BITS  = 16;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEBOUNCE_TIME   = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_REPEAT_DELAY    = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_REPEAT_INTERVAL = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LONG_PRESS_TIME = 2'd3;

   localparam logic [CSR_DATA_BITS-1:0] DEBOUNCE_TIME_RESET   = 16'd25;
   localparam logic [CSR_DATA_BITS-1:0] REPEAT_DELAY_RESET    = 16'd380;
   localparam logic [CSR_DATA_BITS-1:0] REPEAT_INTERVAL_RESET = 16'd110;
   localparam logic [CSR_DATA_BITS-1:0] LONG_PRESS_TIME_RESET = 16'd550;

   typedef struct packed {
      logic [31:0] now_time;
      logic        up_level;
      logic        down_level;
      logic        ok_level;
   } req_type;

   typedef struct packed {
      logic up_event;
      logic down_event;
      logic ok_event;
      logic back_event;
   } rsp_type;

   // per-button debounce outcome for the current request
   typedef struct packed {
      logic press;        // press confirmed by this request
      logic stable_prev;  // debounced state before this request
      logic stable_next;  // debounced state after this request
   } settle_type;

endpackage

`default_nettype wire

>>> rtl/core/bdrl_debounce.sv
// bdrl_debounce: debounce of one active-low button
// holds last raw level, debounced level and time of the last raw change
// depends on bdrl_pkg
`default_nettype none

module bdrl_debounce #(
   parameter int TIME_BITS = 32
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               accept,
   input  wire logic [TIME_BITS-1:0]               now,
   input  wire logic                               level,
   input  wire logic [bdrl_pkg::CSR_DATA_BITS-1:0] debounce_time,
   output      bdrl_pkg::settle_type               settle
);
   import bdrl_pkg::*;

   logic                 last_raw_ff, last_raw_in;
   logic                 stable_ff, stable_in;
   logic [TIME_BITS-1:0] change_time_ff, change_time_in;
   logic                 raw;
   logic [TIME_BITS-1:0] held;
   logic                 settled;

   assign raw     = ~level;
   assign held    = now - change_time_ff;
   assign settled = held >= TIME_BITS'(debounce_time);

   always_comb begin
      last_raw_in    = last_raw_ff;
      stable_in      = stable_ff;
      change_time_in = change_time_ff;
      settle.press   = 1'b0;
      if (raw != last_raw_ff) begin
         // a raw change only restarts the window
         last_raw_in    = raw;
         change_time_in = now;
      end else if (settled) begin
         if (raw && !stable_ff) begin
            stable_in    = 1'b1;
            settle.press = 1'b1;
         end else if (!raw && stable_ff) begin
            stable_in = 1'b0;
         end
      end
      settle.stable_prev = stable_ff;
      settle.stable_next = stable_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_raw_ff    <= 1'b0;
         stable_ff      <= 1'b0;
         change_time_ff <= '0;
      end else if (accept) begin
         last_raw_ff    <= last_raw_in;
         stable_ff      <= stable_in;
         change_time_ff <= change_time_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/bdrl_repeat.sv
// bdrl_repeat: press and auto-repeat events for a scroll button
// holds the next repeat due time; takes the debounce outcome of the button
// depends on bdrl_pkg
`default_nettype none

module bdrl_repeat #(
   parameter int TIME_BITS = 32
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               accept,
   input  wire logic [TIME_BITS-1:0]               now,
   input  wire bdrl_pkg::settle_type               settle,
   input  wire logic [bdrl_pkg::CSR_DATA_BITS-1:0] repeat_delay,
   input  wire logic [bdrl_pkg::CSR_DATA_BITS-1:0] repeat_interval,
   output      logic                               scroll_event
);
   import bdrl_pkg::*;

   logic [TIME_BITS-1:0] due_ff, due_in;
   logic [TIME_BITS-1:0] lag;
   logic                 due_reached;

   // signed wrapped difference: due when not negative
   assign lag         = now - due_ff;
   assign due_reached = ~lag[TIME_BITS-1];

   always_comb begin
      scroll_event = settle.press | (settle.stable_next & due_reached);
      if (settle.press) begin
         due_in = now + TIME_BITS'(repeat_delay);
      end else begin
         due_in = now + TIME_BITS'(repeat_interval);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         due_ff <= '0;
      end else if (accept && scroll_event) begin
         due_ff <= due_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/bdrl_longpress.sv
// bdrl_longpress: short press and long press detection for the ok button
// holds press start time and the back-given flag
// depends on bdrl_pkg
`default_nettype none

module bdrl_longpress #(
   parameter int TIME_BITS = 32
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               accept,
   input  wire logic [TIME_BITS-1:0]               now,
   input  wire bdrl_pkg::settle_type               settle,
   input  wire logic [bdrl_pkg::CSR_DATA_BITS-1:0] long_press_time,
   output      logic                               ok_event,
   output      logic                               back_event
);
   import bdrl_pkg::*;

   logic [TIME_BITS-1:0] start_ff, start_in;
   logic                 done_ff, done_in;
   logic [TIME_BITS-1:0] hold;

   // a press confirmed now restarts the hold from this request
   assign start_in = settle.press ? now : start_ff;
   assign hold     = now - start_in;

   always_comb begin
      done_in    = settle.press ? 1'b0 : done_ff;
      ok_event   = 1'b0;
      back_event = 1'b0;
      if (settle.stable_next) begin
         if (!done_in && (hold >= TIME_BITS'(long_press_time))) begin
            back_event = 1'b1;
            done_in    = 1'b1;
         end
      end else if (settle.stable_prev && !done_in) begin
         ok_event = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0;
         done_ff  <= 1'b0;
      end else if (accept) begin
         start_ff <= start_in;
         done_ff  <= done_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/button_debounce_repeat_longpress.sv
// button_debounce_repeat_longpress: three-button panel front end
// one poll request in, one event response out, every cycle while rsp_stall is low.
//
// req_data carries a millisecond timestamp and the raw active-low levels
// of the up, down and ok buttons. every accepted request gives exactly one
// response on rsp_data with the up, down, ok and back event flags.
// csr_wr_en/csr_index/csr_wdata set the debounce time, repeat delay,
// repeat interval and long-press time; write them only while idle.
// the response is valid in the cycle after the request is taken, from a
// single output register. throughput: one request per cycle while rsp_stall
// is low; per-poll work is a few subtract-and-compare steps on button state.
// when rsp_stall is high with a response held, req_stall rises in the same
// cycle and the held response stays put until taken.
// reset (synchronous) clears all button state, drops rsp_valid and loads
// the csr defaults 25, 380, 110 and 550 ms.
// depends on bdrl_pkg, bdrl_debounce, bdrl_repeat, bdrl_longpress
`default_nettype none

module button_debounce_repeat_longpress #(
   parameter int TIME_BITS = 32
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output      logic                                req_stall,
   input  wire bdrl_pkg::req_type                   req_data,
   output      logic                                rsp_valid,
   input  wire logic                                rsp_stall,
   output      bdrl_pkg::rsp_type                   rsp_data,
   input  wire logic                                csr_wr_en,
   input  wire logic [bdrl_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [bdrl_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import bdrl_pkg::*;

   logic [CSR_DATA_BITS-1:0] debounce_time_ff;
   logic [CSR_DATA_BITS-1:0] repeat_delay_ff;
   logic [CSR_DATA_BITS-1:0] repeat_interval_ff;
   logic [CSR_DATA_BITS-1:0] long_press_time_ff;

   logic                 accept;
   logic [TIME_BITS-1:0] now;
   settle_type           up_settle, down_settle, ok_settle;
   rsp_type              rsp_in;
   rsp_type              rsp_ff;
   logic                 rsp_valid_ff;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign now       = TIME_BITS'(req_data.now_time);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_time_ff   <= DEBOUNCE_TIME_RESET;
         repeat_delay_ff    <= REPEAT_DELAY_RESET;
         repeat_interval_ff <= REPEAT_INTERVAL_RESET;
         long_press_time_ff <= LONG_PRESS_TIME_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_DEBOUNCE_TIME:   debounce_time_ff   <= csr_wdata;
            CSR_REPEAT_DELAY:    repeat_delay_ff    <= csr_wdata;
            CSR_REPEAT_INTERVAL: repeat_interval_ff <= csr_wdata;
            CSR_LONG_PRESS_TIME: long_press_time_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   bdrl_debounce #(.TIME_BITS(TIME_BITS)) u_up_debounce (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .now           (now),
      .level         (req_data.up_level),
      .debounce_time (debounce_time_ff),
      .settle        (up_settle)
   );

   bdrl_debounce #(.TIME_BITS(TIME_BITS)) u_down_debounce (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .now           (now),
      .level         (req_data.down_level),
      .debounce_time (debounce_time_ff),
      .settle        (down_settle)
   );

   bdrl_debounce #(.TIME_BITS(TIME_BITS)) u_ok_debounce (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .now           (now),
      .level         (req_data.ok_level),
      .debounce_time (debounce_time_ff),
      .settle        (ok_settle)
   );

   bdrl_repeat #(.TIME_BITS(TIME_BITS)) u_up_repeat (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .now             (now),
      .settle          (up_settle),
      .repeat_delay    (repeat_delay_ff),
      .repeat_interval (repeat_interval_ff),
      .scroll_event    (rsp_in.up_event)
   );

   bdrl_repeat #(.TIME_BITS(TIME_BITS)) u_down_repeat (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .now             (now),
      .settle          (down_settle),
      .repeat_delay    (repeat_delay_ff),
      .repeat_interval (repeat_interval_ff),
      .scroll_event    (rsp_in.down_event)
   );

   bdrl_longpress #(.TIME_BITS(TIME_BITS)) u_ok_longpress (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .now             (now),
      .settle          (ok_settle),
      .long_press_time (long_press_time_ff),
      .ok_event        (rsp_in.ok_event),
      .back_event      (rsp_in.back_event)
   );

   // output register: loads on accept, empties when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

`ifndef ASSERT_OFF
   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted request did not produce a response");

   a_ok_back_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.ok_event && rsp_data.back_event))
      else $error("ok and back events in the same response");

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");
`endif

endmodule

`default_nettype wire

>>> tb/sv/button_debounce_repeat_longpress_tb.sv
`timescale 1ns / 100ps
// button_debounce_repeat_longpress_tb: self-checking bench for the three-button panel block
// drives poll requests, predicts the up/down/ok/back events and checks every response
// depends on bdrl_pkg and button_debounce_repeat_longpress

module button_debounce_repeat_longpress_tb;
   import bdrl_pkg::*;

   localparam int BTN_UP = 0;
   localparam int BTN_DOWN = 1;
   localparam int BTN_OK = 2;
   localparam int DIRECTED_ROWS = 26;
   localparam int PHASES = 8;
   localparam int PHASE_POLLS = 155;
   localparam int WATCHDOG_LIMIT = 2000;

   // one directed row: request, whether the response is typed in, typed response
   typedef struct packed {
      req_type req;
      bit      typed;
      rsp_type want;
   } dir_row_type;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   req_type                   req_data;
   logic                      rsp_valid;
   logic                      rsp_stall;
   rsp_type                   rsp_data;
   logic                      csr_wr_en;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   // predicted button state
   bit [2:0]  raw_seen;
   bit [2:0]  held;
   bit [31:0] chg_time [3];
   bit [31:0] repeat_at [2];
   bit [31:0] ok_start;
   bit        back_given;
   bit [15:0] cfg_debounce;
   bit [15:0] cfg_rpt_delay;
   bit [15:0] cfg_rpt_interval;
   bit [15:0] cfg_long_press;

   rsp_type   expected_events [$];
   bit [31:0] now_ms;
   int        send_pct;
   int        stall_pct;
   int        failures;
   int        polls_sent;
   int        events_checked;
   int        quiet_cycles;
   int        up_seen, down_seen, ok_seen, back_seen;

   button_debounce_repeat_longpress dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic bit chance(input int pct);
      return $urandom_range(0, 99) < pct;
   endfunction

   // debounce one button; returns 1 on a newly confirmed press
   function automatic bit settle_button(input int k, input bit level, input bit [31:0] now);
      bit        raw;
      bit [31:0] gap;
      raw = ~level;
      if (raw != raw_seen[k]) begin
         raw_seen[k] = raw;
         chg_time[k] = now;
         return 1'b0;
      end
      gap = now - chg_time[k];
      if (gap < {16'd0, cfg_debounce})
         return 1'b0;
      if (raw && !held[k]) begin
         held[k] = 1'b1;
         if (k == BTN_OK) begin
            ok_start = now;
            back_given = 1'b0;
         end else begin
            repeat_at[k] = now + {16'd0, cfg_rpt_delay};
         end
         return 1'b1;
      end
      if (!raw && held[k])
         held[k] = 1'b0;
      return 1'b0;
   endfunction

   // press or auto-repeat for up and down
   function automatic bit scroll_button(input int k, input bit level, input bit [31:0] now);
      bit [31:0] lag;
      if (settle_button(k, level, now))
         return 1'b1;
      lag = now - repeat_at[k];
      if (held[k] && !lag[31]) begin
         repeat_at[k] = now + {16'd0, cfg_rpt_interval};
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic rsp_type poll_events(input req_type r);
      rsp_type   ev;
      bit        was;
      bit [31:0] held_for;
      ev = '0;
      ev.up_event = scroll_button(BTN_UP, r.up_level, r.now_time);
      ev.down_event = scroll_button(BTN_DOWN, r.down_level, r.now_time);
      was = held[BTN_OK];
      void'(settle_button(BTN_OK, r.ok_level, r.now_time));
      if (held[BTN_OK]) begin
         held_for = r.now_time - ok_start;
         if (!back_given && held_for >= {16'd0, cfg_long_press}) begin
            ev.back_event = 1'b1;
            back_given = 1'b1;
         end
      end else if (was && !back_given) begin
         ev.ok_event = 1'b1;
      end
      return ev;
   endfunction

   // levels are {up, down, ok}, events are {up, down, ok, back}
   function automatic dir_row_type directed_row(input int i);
      case (i)
         0:  directed_row = {32'd0,    3'b111, 1'b1, 4'b0000};
         1:  directed_row = {32'd200,  3'b011, 1'b1, 4'b0000};
         2:  directed_row = {32'd224,  3'b011, 1'b1, 4'b0000};
         3:  directed_row = {32'd225,  3'b011, 1'b1, 4'b1000};
         4:  directed_row = {32'd604,  3'b011, 1'b1, 4'b0000};
         5:  directed_row = {32'd605,  3'b011, 1'b1, 4'b1000};
         6:  directed_row = {32'd700,  3'b111, 1'b1, 4'b0000};
         7:  directed_row = {32'd730,  3'b111, 1'b1, 4'b0000};
         8:  directed_row = {32'd800,  3'b101, 1'b1, 4'b0000};
         9:  directed_row = {32'd825,  3'b101, 1'b1, 4'b0100};
         10: directed_row = {32'd830,  3'b111, 1'b1, 4'b0000};
         11: directed_row = {32'd860,  3'b111, 1'b1, 4'b0000};
         12: directed_row = {32'd1000, 3'b110, 1'b1, 4'b0000};
         13: directed_row = {32'd1025, 3'b110, 1'b1, 4'b0000};
         14: directed_row = {32'd1100, 3'b111, 1'b1, 4'b0000};
         15: directed_row = {32'd1125, 3'b111, 1'b1, 4'b0010};
         16: directed_row = {32'd2000, 3'b110, 1'b1, 4'b0000};
         17: directed_row = {32'd2025, 3'b110, 1'b1, 4'b0000};
         18: directed_row = {32'd2575, 3'b110, 1'b1, 4'b0001};
         19: directed_row = {32'd2600, 3'b111, 1'b1, 4'b0000};
         20: directed_row = {32'd2625, 3'b111, 1'b1, 4'b0000};
         21: directed_row = {32'd3000, 3'b000, 1'b1, 4'b0000};
         22: directed_row = {32'd3025, 3'b000, 1'b1, 4'b1100};
         // time at its top and wrapping back to zero
         23: directed_row = {32'hFFFF_FFFF, 3'b000, 1'b0, 4'b0000};
         24: directed_row = {32'd0,    3'b111, 1'b0, 4'b0000};
         default: directed_row = {32'd25, 3'b111, 1'b1, 4'b0000};
      endcase
   endfunction

   // called just after a falling edge, returns just after a falling edge
   task automatic send_poll(input req_type r, input bit typed, input rsp_type typed_want);
      rsp_type want;
      bit      taken;
      taken = 1'b0;
      while (chance(send_pct)) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_data = r;
      req_valid = 1'b1;
      while (!taken) begin
         @(posedge clock);
         taken = !req_stall;
         if (taken) begin
            want = poll_events(r);
            expected_events.push_back(typed ? typed_want : want);
            polls_sent++;
         end
         @(negedge clock);
      end
   endtask

   task automatic push_poll(input bit [2:0] lv);
      req_type r;
      r.now_time = now_ms;
      r.up_level = lv[2];
      r.down_level = lv[1];
      r.ok_level = lv[0];
      send_poll(r, 1'b0, '0);
   endtask

   // sender holds off until every pending response is back
   task automatic drain_responses;
      req_valid = 1'b0;
      while (expected_events.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_config(input bit [15:0] deb, input bit [15:0] rdly,
                               input bit [15:0] rint, input bit [15:0] lp);
      csr_wr_en = 1'b1;
      csr_index = CSR_DEBOUNCE_TIME;
      csr_wdata = deb;
      @(negedge clock);
      csr_index = CSR_REPEAT_DELAY;
      csr_wdata = rdly;
      @(negedge clock);
      csr_index = CSR_REPEAT_INTERVAL;
      csr_wdata = rint;
      @(negedge clock);
      csr_index = CSR_LONG_PRESS_TIME;
      csr_wdata = lp;
      @(negedge clock);
      csr_wr_en = 1'b0;
      cfg_debounce = deb;
      cfg_rpt_delay = rdly;
      cfg_rpt_interval = rint;
      cfg_long_press = lp;
   endtask

   // mostly bounce-then-hold button gestures, some wild time jumps
   task automatic run_phase(input int budget, input int step_max);
      int       sent;
      int       hold;
      int       bounce;
      bit [2:0] lv;
      sent = 0;
      while (sent < budget) begin
         if (chance(15)) begin
            case ($urandom_range(0, 2))
               0: now_ms = $urandom();
               1: now_ms = now_ms + 32'h7FFF_FFFF + $urandom_range(0, 2);
               default: now_ms = now_ms - $urandom_range(0, step_max);
            endcase
            push_poll(3'($urandom_range(0, 7)));
            sent++;
         end else begin
            lv = 3'($urandom_range(0, 7));
            bounce = chance(40) ? $urandom_range(1, 6) : 0;
            repeat (bounce) begin
               now_ms = now_ms + $urandom_range(0, step_max / 4 + 1);
               push_poll(lv ^ 3'($urandom_range(0, 7)));
               sent++;
            end
            hold = $urandom_range(1, 40);
            repeat (hold) begin
               now_ms = now_ms + $urandom_range(0, step_max);
               push_poll(lv);
               sent++;
            end
         end
      end
   endtask

   always @(negedge clock)
      rsp_stall = chance(stall_pct);

   task automatic check_field(input string name, input bit want, input logic got);
      if (got !== want) begin
         $error("%s: expected %0b, got %0b", name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("button_debounce_repeat_longpress_tb: done, errors");
            $finish;
         end else if (rsp_valid && !rsp_stall) begin
            if (expected_events.size() == 0) begin
               $error("response with no request pending");
               failures++;
            end else begin
               want = expected_events.pop_front();
               check_field("up_event", want.up_event, rsp_data.up_event);
               check_field("down_event", want.down_event, rsp_data.down_event);
               check_field("ok_event", want.ok_event, rsp_data.ok_event);
               check_field("back_event", want.back_event, rsp_data.back_event);
               events_checked++;
            end
            up_seen += rsp_data.up_event;
            down_seen += rsp_data.down_event;
            ok_seen += rsp_data.ok_event;
            back_seen += rsp_data.back_event;
         end
      end
   end

   initial begin
      dir_row_type row;
      bit [15:0]   v [4];
      int          step_max;
      int          top;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = CSR_DEBOUNCE_TIME;
      csr_wdata = '0;
      send_pct = 0;
      stall_pct = 0;
      failures = 0;
      polls_sent = 0;
      events_checked = 0;
      up_seen = 0;
      down_seen = 0;
      ok_seen = 0;
      back_seen = 0;
      raw_seen = '0;
      held = '0;
      chg_time = '{default: '0};
      repeat_at = '{default: '0};
      ok_start = '0;
      back_given = 1'b0;
      cfg_debounce = DEBOUNCE_TIME_RESET;
      cfg_rpt_delay = REPEAT_DELAY_RESET;
      cfg_rpt_interval = REPEAT_INTERVAL_RESET;
      cfg_long_press = LONG_PRESS_TIME_RESET;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed gestures with the reset settings
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         row = directed_row(i);
         send_poll(row.req, row.typed, row.want);
      end
      drain_responses();
      now_ms = 32'd25;

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: v = '{DEBOUNCE_TIME_RESET, REPEAT_DELAY_RESET,
                     REPEAT_INTERVAL_RESET, LONG_PRESS_TIME_RESET};
            1: v = '{16'd0, 16'd0, 16'd0, 16'd0};
            3: v = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
            4: v = '{16'd0, 16'hFFFF, 16'd0, 16'd0};
            5: v = '{16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom())};
            7: v = '{16'd1, 16'd1, 16'd1, 16'd1};
            default: v = '{16'($urandom_range(0, 30)), 16'($urandom_range(0, 400)),
                           16'($urandom_range(0, 120)), 16'($urandom_range(0, 600))};
         endcase
         write_config(v[0], v[1], v[2], v[3]);
         top = 0;
         foreach (v[j])
            if (v[j] > top)
               top = v[j];
         step_max = top / 4 + 2;
         case (phase % 4)
            0: begin send_pct = 0;  stall_pct = 0;  end
            1: begin send_pct = 68; stall_pct = 0;  end
            2: begin send_pct = 0;  stall_pct = 68; end
            default: begin send_pct = 14; stall_pct = 14; end
         endcase
         run_phase(PHASE_POLLS, step_max);
         drain_responses();
      end

      repeat (4) @(negedge clock);
      $display("covered %0d polls over %0d register settings, %0d responses checked",
               polls_sent, PHASES + 1, events_checked);
      $display("events seen: up %0d, down %0d, ok %0d, back %0d",
               up_seen, down_seen, ok_seen, back_seen);
      if (failures == 0)
         $display("button_debounce_repeat_longpress_tb: done, clean");
      else
         $display("button_debounce_repeat_longpress_tb: done, errors");
      $finish;
   end

endmodule
